[src/touch_track_direction_vote_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef TOUCH_TRACK_DIRECTION_VOTE_CORE_ASSERT_SVH
`define TOUCH_TRACK_DIRECTION_VOTE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TTDV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ttdv assertion failed");

// Next-cycle implication, checked during reset as well.
`define TTDV_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ttdv assertion failed");

`endif

[src/ttdv_pkg.sv]
// Types and constants of the touch direction vote block.
`default_nettype none
package ttdv_pkg;

    localparam int DIR_BINS = 7;
    localparam int POS_W    = 15;
    localparam int DISP_W   = 16;

    typedef enum logic [2:0] {
        OP_MATCH = 3'd0,
        OP_LOST  = 3'd1,
        OP_NEW   = 3'd2,
        OP_EOF   = 3'd3,
        OP_CLEAR = 3'd4,
        OP_ZERO  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        DIR_UNKNOWN = 3'd0,
        DIR_STILL   = 3'd1,
        DIR_MOVE    = 3'd2,
        DIR_LEFT    = 3'd3,
        DIR_RIGHT   = 3'd4,
        DIR_UP      = 3'd5,
        DIR_DOWN    = 3'd6
    } dir_t;

    typedef enum logic [2:0] {
        CFG_X_THR   = 3'd0,
        CFG_Y_THR   = 3'd1,
        CFG_X_RATIO = 3'd2,
        CFG_Y_RATIO = 3'd3,
        CFG_MIN_CNT = 3'd4,
        CFG_MAX_CNT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOTE,
        ST_PICK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [7:0]        touch_id;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } in_item_t;

    typedef struct packed {
        dir_t              direction;
        logic [4:0]        voter_count;
        logic signed [DISP_W-1:0] mean_dx;
        logic signed [DISP_W-1:0] mean_dy;
        logic [POS_W-1:0]  mean_x;
        logic [POS_W-1:0]  mean_y;
    } out_item_t;

    // Request broadcast to every cell.
    typedef struct packed {
        logic              fire;
        op_t               op;
        logic [7:0]        id;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
    } cell_req_t;

    // Data rippled from cell to cell.
    typedef struct packed {
        logic              free_seen;
        logic              hit;
        logic [DISP_W-1:0] ndx;
        logic [DISP_W-1:0] ndy;
    } chain_t;

endpackage
`default_nettype wire

[src/touch_track_direction_vote_core.sv]
// Touch tracker with per-frame direction vote: a row of entry cells, seven vote bins
// and a serial divider for the bin means. Every touch report (matched, lost, new,
// clear, zero) passes the id search through the cell row and then the vote state,
// in which a matched report of a tracked id is counted into the bins. An end-of-frame
// request picks the winning bin and then runs four divisions on the shared bit-serial
// divider; with no winning bin it skips the divisions.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module touch_track_direction_vote_core
    import ttdv_pkg::*;
#(
    parameter int MAX_TOUCHES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [14:0] cfg_wr_data
);

    localparam int VW = $clog2(MAX_TOUCHES + 1);
    localparam int PW = POS_W + VW;
    localparam int NW = PW + 2;

    // configuration
    logic [14:0] x_thr_reg, y_thr_reg;
    logic [7:0]  x_ratio_reg, y_ratio_reg;
    logic [4:0]  min_cnt_reg, max_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_thr_reg   <= '0;
            y_thr_reg   <= '0;
            x_ratio_reg <= 8'd1;
            y_ratio_reg <= 8'd1;
            min_cnt_reg <= 5'd1;
            max_cnt_reg <= 5'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_X_THR:   x_thr_reg   <= cfg_wr_data;
                CFG_Y_THR:   y_thr_reg   <= cfg_wr_data;
                CFG_X_RATIO: x_ratio_reg <= cfg_wr_data[7:0];
                CFG_Y_RATIO: y_ratio_reg <= cfg_wr_data[7:0];
                CFG_MIN_CNT: min_cnt_reg <= cfg_wr_data[4:0];
                CFG_MAX_CNT: max_cnt_reg <= cfg_wr_data[4:0];
                default:     ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic   accept;
    logic   div_start, div_done;
    logic signed [NW-1:0] div_quo;
    logic [1:0] k_reg;

    assign accept = s_valid && s_ready;

    // cell row
    cell_req_t req;
    chain_t    chain [MAX_TOUCHES+1];
    logic      global_hit;

    assign req.fire = accept;
    assign req.op   = s_data.operation;
    assign req.id   = s_data.touch_id;
    assign req.px   = s_data.pos_x;
    assign req.py   = s_data.pos_y;
    assign chain[0] = '0;
    assign global_hit = chain[MAX_TOUCHES].hit;

    for (genvar g = 0; g < MAX_TOUCHES; g++) begin : g_cell
        ttdv_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .req        (req),
            .global_hit (global_hit),
            .chain_in   (chain[g]),
            .chain_out  (chain[g+1])
        );
    end

    // vote stage registers
    logic              vote_pend_reg;
    logic [DISP_W-1:0] vdx_reg, vdy_reg;
    logic [POS_W-1:0]  vpx_reg, vpy_reg;
    logic [4:0]        frame_cnt_reg;
    logic [VW-1:0]     frame_votes_reg;

    logic [VW-1:0]     bin_cnt_reg [DIR_BINS];
    logic [DISP_W-1:0] bin_dx_reg  [DIR_BINS];
    logic [DISP_W-1:0] bin_dy_reg  [DIR_BINS];
    logic [PW-1:0]     bin_px_reg  [DIR_BINS];
    logic [PW-1:0]     bin_py_reg  [DIR_BINS];

    // bin selection
    logic [DISP_W-1:0] ax, ay;
    logic [23:0]       xprod, yprod;
    dir_t              vbin;

    always_comb begin
        ax    = vdx_reg[DISP_W-1] ? -vdx_reg : vdx_reg;
        ay    = vdy_reg[DISP_W-1] ? -vdy_reg : vdy_reg;
        xprod = 24'(x_ratio_reg) * 24'(ay);
        yprod = 24'(y_ratio_reg) * 24'(ax);
        if ({1'b0, x_thr_reg} > ax && {1'b0, y_thr_reg} > ay)
            vbin = DIR_STILL;
        else if ({8'd0, ax} > xprod)
            vbin = vdx_reg[DISP_W-1] ? DIR_LEFT : DIR_RIGHT;
        else if ({8'd0, ay} > yprod)
            vbin = vdy_reg[DISP_W-1] ? DIR_UP : DIR_DOWN;
        else
            vbin = DIR_MOVE;
    end

    // winner search
    logic          in_limits;
    logic [2:0]    best;
    logic [VW-1:0] most;

    always_comb begin
        in_limits = (frame_cnt_reg >= min_cnt_reg) && (frame_cnt_reg <= max_cnt_reg);
        best = '0;
        most = '0;
        if (in_limits) begin
            for (int i = 0; i < DIR_BINS; i++) begin
                if (bin_cnt_reg[i] > most) begin
                    most = bin_cnt_reg[i];
                    best = 3'(i);
                end
            end
        end
    end

    logic signed [NW-1:0] num_reg [4];
    logic signed [NW-1:0] q_reg   [4];
    logic [2:0]           best_reg;
    logic [VW-1:0]        most_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cnt_reg   <= '0;
            frame_votes_reg <= '0;
            vote_pend_reg   <= 1'b0;
            for (int i = 0; i < DIR_BINS; i++) begin
                bin_cnt_reg[i] <= '0;
                bin_dx_reg[i]  <= '0;
                bin_dy_reg[i]  <= '0;
                bin_px_reg[i]  <= '0;
                bin_py_reg[i]  <= '0;
            end
        end else begin
            if (accept) begin
                if (s_data.operation == OP_MATCH || s_data.operation == OP_NEW) begin
                    if (frame_cnt_reg != 5'd31)
                        frame_cnt_reg <= frame_cnt_reg + 5'd1;
                end
                vote_pend_reg <= (s_data.operation == OP_MATCH) && global_hit
                                 && (frame_votes_reg < VW'(MAX_TOUCHES));
            end
            if (state_reg == ST_VOTE && vote_pend_reg) begin
                frame_votes_reg <= frame_votes_reg + VW'(1);
                for (int i = 0; i < DIR_BINS; i++) begin
                    if (vbin == dir_t'(i)) begin
                        bin_cnt_reg[i] <= bin_cnt_reg[i] + VW'(1);
                        bin_dx_reg[i]  <= bin_dx_reg[i] + vdx_reg;
                        bin_dy_reg[i]  <= bin_dy_reg[i] + vdy_reg;
                        bin_px_reg[i]  <= bin_px_reg[i] + PW'(vpx_reg);
                        bin_py_reg[i]  <= bin_py_reg[i] + PW'(vpy_reg);
                    end
                end
            end
            if (state_reg == ST_PICK) begin
                // clear bins once the winner is latched
                frame_cnt_reg   <= '0;
                frame_votes_reg <= '0;
                for (int i = 0; i < DIR_BINS; i++) begin
                    bin_cnt_reg[i] <= '0;
                    bin_dx_reg[i]  <= '0;
                    bin_dy_reg[i]  <= '0;
                    bin_px_reg[i]  <= '0;
                    bin_py_reg[i]  <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vdx_reg <= chain[MAX_TOUCHES].ndx;
            vdy_reg <= chain[MAX_TOUCHES].ndy;
            vpx_reg <= s_data.pos_x;
            vpy_reg <= s_data.pos_y;
        end
        if (state_reg == ST_PICK) begin
            best_reg   <= best;
            most_reg   <= most;
            num_reg[0] <= $signed({{(NW-DISP_W){bin_dx_reg[best][DISP_W-1]}},
                                   bin_dx_reg[best]}) + $signed(NW'(most)) - NW'(1);
            num_reg[1] <= $signed({{(NW-DISP_W){bin_dy_reg[best][DISP_W-1]}},
                                   bin_dy_reg[best]}) + $signed(NW'(most)) - NW'(1);
            num_reg[2] <= $signed(NW'(bin_px_reg[best])) + $signed(NW'(most)) - NW'(1);
            num_reg[3] <= $signed(NW'(bin_py_reg[best])) + $signed(NW'(most)) - NW'(1);
        end
        if (state_reg == ST_DIV_WAIT && div_done)
            q_reg[k_reg] <= div_quo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (state_reg == ST_PICK) begin
            k_reg <= '0;
        end else if (state_reg == ST_DIV_WAIT && div_done) begin
            k_reg <= k_reg + 2'd1;
        end
    end

    ttdv_div #(
        .NW (NW),
        .DW (VW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg[k_reg]),
        .den     (most_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == OP_EOF) state_next = ST_PICK;
                    else                            state_next = ST_VOTE;
                end
            end
            ST_VOTE:      state_next = ST_IDLE;
            ST_PICK:      state_next = (most == '0) ? ST_OUT : ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) state_next = (k_reg == 2'd3) ? ST_OUT : ST_DIV_START;
            end
            ST_OUT:       if (!m_valid || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV_START);
    end

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            if (most_reg == '0) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg.direction   <= dir_t'(best_reg);
                m_data_reg.voter_count <= 5'(most_reg);
                m_data_reg.mean_dx     <= q_reg[0][DISP_W-1:0];
                m_data_reg.mean_dy     <= q_reg[1][DISP_W-1:0];
                m_data_reg.mean_x      <= q_reg[2][POS_W-1:0];
                m_data_reg.mean_y      <= q_reg[3][POS_W-1:0];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

[src/ttdv_cell.sv]
// One tracked-touch entry of the cell row.
`default_nettype none
module ttdv_cell
    import ttdv_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_req_t req,
    input  wire logic      global_hit,
    input  wire chain_t    chain_in,
    output chain_t         chain_out
);

    logic              valid_reg;
    logic [7:0]        id_reg;
    logic [POS_W-1:0]  px_reg, py_reg;
    logic [DISP_W-1:0] dx_reg, dy_reg;

    logic              match;
    logic [DISP_W-1:0] ndx, ndy;

    assign match = valid_reg && (id_reg == req.id);
    assign ndx = dx_reg + ({1'b0, req.px} - {1'b0, px_reg});
    assign ndy = dy_reg + ({1'b0, req.py} - {1'b0, py_reg});

    always_comb begin
        chain_out.free_seen = chain_in.free_seen | ~valid_reg;
        chain_out.hit       = chain_in.hit | match;
        chain_out.ndx       = chain_in.ndx | (match ? ndx : '0);
        chain_out.ndy       = chain_in.ndy | (match ? ndy : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (req.fire) begin
            case (req.op)
                OP_LOST:  if (match) valid_reg <= 1'b0;
                OP_NEW:   if (match || (!global_hit && !valid_reg && !chain_in.free_seen))
                              valid_reg <= 1'b1;
                OP_CLEAR: valid_reg <= 1'b0;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (req.fire) begin
            case (req.op)
                OP_MATCH: begin
                    if (match) begin
                        dx_reg <= ndx;
                        dy_reg <= ndy;
                        px_reg <= req.px;
                        py_reg <= req.py;
                    end
                end
                OP_NEW: begin
                    // restart a tracked id, or take the first free slot
                    if (match || (!global_hit && !valid_reg && !chain_in.free_seen)) begin
                        id_reg <= req.id;
                        px_reg <= req.px;
                        py_reg <= req.py;
                        dx_reg <= '0;
                        dy_reg <= '0;
                    end
                end
                OP_ZERO: begin
                    dx_reg <= '0;
                    dy_reg <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/ttdv_div.sv]
// Bit-serial signed-by-unsigned divider, truncating toward zero.
`default_nettype none
module ttdv_div #(
    parameter int NW = 22,
    parameter int DW = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] num,
    input  wire logic [DW-1:0]        den,
    output logic                      done,
    output logic signed [NW-1:0]      quo
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, done_reg, neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] acc_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_reg, acc_reg[NW-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NW-1];
            acc_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            rem_reg <= '0;
            cnt_reg <= CW'(NW);
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            acc_reg <= {acc_reg[NW-2:0], ge};
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule
`default_nettype wire

[src/ttdv_checker.sv]
// Port-level checker for the touch direction vote core, with its bind.
`default_nettype none
`include "touch_track_direction_vote_core_assert.svh"
module ttdv_checker
    import ttdv_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    `TTDV_ASSERT_NOW(a_hold, aclk, aresetn, m_valid && !m_ready, ##1 (m_valid && $stable(m_data)))
    `TTDV_ASSERT_NOW(a_unknown_empty, aclk, aresetn, m_valid && m_data.direction == DIR_UNKNOWN, m_data.voter_count == 5'd0 && m_data.mean_x == '0 && m_data.mean_y == '0)
    `TTDV_ASSERT_NOW(a_vote_counted, aclk, aresetn, m_valid && m_data.direction != DIR_UNKNOWN, m_data.voter_count != 5'd0)
    `TTDV_ASSERT_NEXT(a_reset_idle, aclk, !aresetn, !m_valid)

endmodule

bind touch_track_direction_vote_core ttdv_checker u_ttdv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
